// File: sv/md5_pkg.sv
// Package for the MD5 digest block: payload structs, sequencer states,
// initial chaining values and the per-round constant and shift tables.
// No dependencies.
package md5_pkg;

  // Input request: one message byte plus framing flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_t;

  // Result request: 128-bit digest, byte 0 in digest_low[7:0]
  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMPRESS,
    ST_ADD,
    ST_FIN
  } state_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_RND = 6'd63;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  // Rotate amount for round r
  function automatic logic [4:0] shift_amt(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // Additive constant for round r
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Message word index for round r
  function automatic logic [3:0] word_idx(input logic [5:0] r);
    logic [3:0] g;
    unique case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: g = r[3:0] * 4'd5 + 4'd1;
      2'd2: g = r[3:0] * 4'd3 + 4'd5;
      2'd3: g = r[3:0] * 4'd7;
      default: g = r[3:0];
    endcase
    return g;
  endfunction

endpackage

// File: sv/md5_message_digest.sv
// MD5 digest engine: byte packing, padding sequencer and one shared round unit.
// Depends on md5_pkg (payload structs, states, constant tables).
//
// Usage: the in_ channel carries one request per message byte (has_byte) and
// marks the final request with is_last; an is_last request without a byte is
// allowed and closes the message. The out_ channel carries one 128-bit digest
// per message, byte 0 in digest_low[7:0].
// Operation: a byte request is taken while the sequencer is idle. A request
// that fills the 64-byte block holds in_ready low through 64 rounds, one round
// a cycle through the single round unit, and one chaining add. A last request
// runs the padding sequencer at one byte a cycle up to the end of the block
// (one extra block when fewer than 9 bytes remain), each block followed by
// the compression and chaining add, then the digest load. A message of n bytes
// fills B = ceil((n + 9) / 64) blocks. The digest sits in an output register;
// the block accepts the next message while it waits. If a second digest is
// ready before the first is taken, the sequencer waits in its final state,
// and in_ready stays low.
// Reset (rst_n low, synchronous) restores the initial chaining values, clears
// the byte count and fill position and drops out_valid. After each digest the
// block restores those same chaining values, byte count and fill position by itself.
module md5_message_digest (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  md5_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output md5_pkg::out_t  out_data
);

  md5_pkg::state_t state_r, state_nxt;

  logic [31:0] block_words_r [16];
  logic [31:0] chain_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [63:0] bit_count_r;
  logic [5:0]  fill_pos_r;
  logic [5:0]  round_r;
  logic        last_pend_r;   // last request filled a block: pad after compress
  logic        pad_active_r;  // padding in progress
  logic        pad_mark_r;    // next pad byte is the 0x80 marker
  logic        len_phase_r;   // writing the length bytes
  logic        done_r;        // final block filled: digest after compress
  logic        out_valid_r;
  md5_pkg::out_t out_data_r;

  logic        in_fire;
  logic        put_en;
  logic [7:0]  put_val;
  logic        pad_len_byte;
  logic        fin_load;

  // Round unit signals
  logic [31:0] f_val;
  logic [31:0] sum_val;
  logic [31:0] rot_val;
  logic [4:0]  rot_amt;

  assign in_fire = in_valid && in_ready;
  assign pad_len_byte = !pad_mark_r && (len_phase_r || (fill_pos_r == md5_pkg::LEN_POS));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      md5_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data.has_byte && (fill_pos_r == md5_pkg::LAST_POS)) begin
            state_nxt = md5_pkg::ST_COMPRESS;
          end else if (in_data.is_last) begin
            state_nxt = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_PAD: begin
        if (fill_pos_r == md5_pkg::LAST_POS) begin
          state_nxt = md5_pkg::ST_COMPRESS;
        end
      end
      md5_pkg::ST_COMPRESS: begin
        if (round_r == md5_pkg::LAST_RND) begin
          state_nxt = md5_pkg::ST_ADD;
        end
      end
      md5_pkg::ST_ADD: begin
        priority if (done_r) begin
          state_nxt = md5_pkg::ST_FIN;
        end else if (last_pend_r || pad_active_r) begin
          state_nxt = md5_pkg::ST_PAD;
        end else begin
          state_nxt = md5_pkg::ST_IDLE;
        end
      end
      md5_pkg::ST_FIN: begin
        if (fin_load) begin
          state_nxt = md5_pkg::ST_IDLE;
        end
      end
      default: state_nxt = md5_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, byte write port, digest load
  always_comb begin
    in_ready = 1'b0;
    put_en   = 1'b0;
    put_val  = in_data.data_byte;
    fin_load = 1'b0;
    unique case (state_r)
      md5_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        put_en   = in_fire && in_data.has_byte;
      end
      md5_pkg::ST_PAD: begin
        put_en = 1'b1;
        priority if (pad_mark_r) begin
          put_val = md5_pkg::PAD_MARK;
        end else if (pad_len_byte) begin
          put_val = bit_count_r[{fill_pos_r[2:0], 3'b000} +: 8];
        end else begin
          put_val = 8'h00;
        end
      end
      md5_pkg::ST_FIN: begin
        fin_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Shared round unit: boolean function, four-term add, rotate, add b
  always_comb begin
    unique case (round_r[5:4])
      2'd0: f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1: f_val = (d_r & b_r) | (~d_r & c_r);
      2'd2: f_val = b_r ^ c_r ^ d_r;
      2'd3: f_val = c_r ^ (b_r | ~d_r);
      default: f_val = b_r ^ c_r ^ d_r;
    endcase
    rot_amt = md5_pkg::shift_amt(round_r);
    sum_val = a_r + f_val + md5_pkg::round_k(round_r)
            + block_words_r[md5_pkg::word_idx(round_r)];
    // shift amounts are never zero, so the right shift stays below 32
    rot_val = (sum_val << rot_amt) | (sum_val >> (6'd32 - {1'b0, rot_amt}));
  end

  // Block buffer: bytes packed little-endian, first byte of a word clears it
  always_ff @(posedge clk) begin
    if (put_en) begin
      if (fill_pos_r[1:0] == 2'd0) begin
        block_words_r[fill_pos_r[5:2]] <= {24'h0, put_val};
      end else begin
        block_words_r[fill_pos_r[5:2]] <= block_words_r[fill_pos_r[5:2]]
                                        | ({24'h0, put_val} << {fill_pos_r[1:0], 3'b000});
      end
    end
  end

  // Control, chaining and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= md5_pkg::ST_IDLE;
      chain_r[0]   <= md5_pkg::INIT_A;
      chain_r[1]   <= md5_pkg::INIT_B;
      chain_r[2]   <= md5_pkg::INIT_C;
      chain_r[3]   <= md5_pkg::INIT_D;
      a_r          <= md5_pkg::INIT_A;
      b_r          <= md5_pkg::INIT_B;
      c_r          <= md5_pkg::INIT_C;
      d_r          <= md5_pkg::INIT_D;
      bit_count_r  <= '0;
      fill_pos_r   <= '0;
      round_r      <= '0;
      last_pend_r  <= 1'b0;
      pad_active_r <= 1'b0;
      pad_mark_r   <= 1'b0;
      len_phase_r  <= 1'b0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (put_en) begin
        fill_pos_r <= fill_pos_r + 6'd1;
      end

      // digest load wins over the handshake that frees the register
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        md5_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (in_data.has_byte) begin
              bit_count_r <= bit_count_r + md5_pkg::BITS_PER_BYTE;
            end
            if (in_data.is_last) begin
              if (in_data.has_byte && (fill_pos_r == md5_pkg::LAST_POS)) begin
                last_pend_r <= 1'b1;
              end else begin
                pad_mark_r   <= 1'b1;
                pad_active_r <= 1'b1;
              end
            end
          end
        end
        md5_pkg::ST_PAD: begin
          pad_mark_r <= 1'b0;
          if (pad_len_byte) begin
            len_phase_r <= 1'b1;
            if (fill_pos_r == md5_pkg::LAST_POS) begin
              done_r <= 1'b1;
            end
          end
        end
        md5_pkg::ST_COMPRESS: begin
          round_r <= round_r + 6'd1;
          a_r <= d_r;
          b_r <= b_r + rot_val;
          c_r <= b_r;
          d_r <= c_r;
        end
        md5_pkg::ST_ADD: begin
          // working registers track the chain so the next block starts from it
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          a_r <= chain_r[0] + a_r;
          b_r <= chain_r[1] + b_r;
          c_r <= chain_r[2] + c_r;
          d_r <= chain_r[3] + d_r;
          if (last_pend_r) begin
            last_pend_r  <= 1'b0;
            pad_mark_r   <= 1'b1;
            pad_active_r <= 1'b1;
          end
        end
        md5_pkg::ST_FIN: begin
          if (fin_load) begin
            chain_r[0]   <= md5_pkg::INIT_A;
            chain_r[1]   <= md5_pkg::INIT_B;
            chain_r[2]   <= md5_pkg::INIT_C;
            chain_r[3]   <= md5_pkg::INIT_D;
            a_r          <= md5_pkg::INIT_A;
            b_r          <= md5_pkg::INIT_B;
            c_r          <= md5_pkg::INIT_C;
            d_r          <= md5_pkg::INIT_D;
            bit_count_r  <= '0;
            fill_pos_r   <= '0;
            pad_active_r <= 1'b0;
            len_phase_r  <= 1'b0;
            done_r       <= 1'b0;
          end
        end
        default: begin
          round_r <= '0;
        end
      endcase
    end
  end

  // Digest output register
  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_data_r.digest_low  <= {chain_r[1], chain_r[0]};
      out_data_r.digest_high <= {chain_r[3], chain_r[2]};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Round counter rests at zero outside compression
  a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != md5_pkg::ST_COMPRESS) |-> (round_r == '0))
    else $error("round counter not zero outside compression");

  // Compression only starts on a full block
  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == md5_pkg::ST_COMPRESS) || (state_r == md5_pkg::ST_ADD)
     || (state_r == md5_pkg::ST_FIN)) |-> (fill_pos_r == '0))
    else $error("compression with partly filled block");

  // Length bytes only occupy the tail of a block
  a_len_tail: assert property (@(posedge clk) disable iff (!rst_n)
    len_phase_r |-> ((fill_pos_r[5:3] == 3'd7) || (fill_pos_r == '0)))
    else $error("length bytes outside block tail");

  // A finished digest is never lost while the previous one waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending digest dropped");

endmodule
